[hw/rtl/idd_pkg.sv]
package idd_pkg;

	// one descriptor beat, six raw words
	typedef struct packed {
		logic [31:0] word_zero;
		logic [31:0] word_one;
		logic [31:0] word_two;
		logic [31:0] word_three;
		logic [31:0] word_four;
		logic [31:0] word_five;
	} idd_in_t;

	// one decoded result beat
	typedef struct packed {
		logic [47:0] base_address;
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic [14:0] row_pitch;
		logic [11:0] min_lod_out;
		logic [13:0] mip_fields;
		logic [16:0] layer_count;
		logic [16:0] view_layer_count;
		logic [15:0] base_slice;
		logic [9:0]  format_pair;
		logic [6:0]  tiling_index;
		logic [6:0]  status_flags;
	} idd_out_t;

	// swizzle modes with a fixed tiling index
	localparam logic [4:0] SWZ_LINEAR = 5'd0;
	localparam logic [4:0] SW_STD_A   = 5'd1;
	localparam logic [4:0] SW_STD_B   = 5'd5;
	localparam logic [4:0] SW_STD_C   = 5'd9;

	// tiling indexes
	localparam logic [6:0] TILE_LINEAR = 7'h08;
	localparam logic [6:0] TILE_STD_A  = 7'h50;
	localparam logic [6:0] TILE_STD_B  = 7'h51;
	localparam logic [6:0] TILE_STD_C  = 7'h52;
	localparam logic [6:0] TILE_BASE   = 7'h40;

	// image types
	localparam logic [3:0] IMG_3D_A    = 4'd10;
	localparam logic [3:0] IMG_3D_B    = 4'd11;
	localparam logic [3:0] IMG_ARRAY_A = 4'd12;
	localparam logic [3:0] IMG_ARRAY_B = 4'd13;

	// data formats that take part in linear pitch alignment
	localparam logic [5:0] DF_NARROW_ALIGN = 6'd12;
	localparam logic [5:0] DF_PITCH_LIMIT  = 6'd35;

	// unified format to {number format, data format}; unknown gives zero
	function automatic logic [9:0] idd_fmt_lookup(input logic [8:0] uf);
		logic [3:0] nf;
		logic [5:0] df;
		nf = 4'd0;
		df = 6'd0;
		case (uf)
			9'd1:   begin df = 6'd1;  nf = 4'd0; end
			9'd2:   begin df = 6'd1;  nf = 4'd1; end
			9'd5:   begin df = 6'd1;  nf = 4'd4; end
			9'd6:   begin df = 6'd1;  nf = 4'd5; end
			9'd7:   begin df = 6'd2;  nf = 4'd0; end
			9'd11:  begin df = 6'd2;  nf = 4'd4; end
			9'd13:  begin df = 6'd2;  nf = 4'd7; end
			9'd14:  begin df = 6'd3;  nf = 4'd0; end
			9'd18:  begin df = 6'd3;  nf = 4'd4; end
			9'd20:  begin df = 6'd4;  nf = 4'd4; end
			9'd21:  begin df = 6'd4;  nf = 4'd5; end
			9'd22:  begin df = 6'd4;  nf = 4'd7; end
			9'd23:  begin df = 6'd5;  nf = 4'd0; end
			9'd27:  begin df = 6'd5;  nf = 4'd4; end
			9'd29:  begin df = 6'd5;  nf = 4'd7; end
			9'd36:  begin df = 6'd6;  nf = 4'd7; end
			9'd44:  begin df = 6'd9;  nf = 4'd0; end
			9'd50:  begin df = 6'd8;  nf = 4'd0; end
			9'd56:  begin df = 6'd10; nf = 4'd0; end
			9'd62:  begin df = 6'd11; nf = 4'd4; end
			9'd64:  begin df = 6'd11; nf = 4'd7; end
			9'd71:  begin df = 6'd12; nf = 4'd7; end
			9'd74:  begin df = 6'd13; nf = 4'd7; end
			9'd77:  begin df = 6'd14; nf = 4'd7; end
			9'd57:  begin df = 6'd10; nf = 4'd1; end
			9'd60:  begin df = 6'd10; nf = 4'd4; end
			9'd130: begin df = 6'd10; nf = 4'd9; end
			9'd169: begin df = 6'd35; nf = 4'd0; end
			9'd170: begin df = 6'd35; nf = 4'd9; end
			9'd171: begin df = 6'd36; nf = 4'd0; end
			9'd172: begin df = 6'd36; nf = 4'd9; end
			9'd173: begin df = 6'd37; nf = 4'd0; end
			9'd174: begin df = 6'd37; nf = 4'd9; end
			9'd175: begin df = 6'd38; nf = 4'd0; end
			9'd176: begin df = 6'd38; nf = 4'd1; end
			9'd177: begin df = 6'd39; nf = 4'd0; end
			9'd178: begin df = 6'd39; nf = 4'd1; end
			9'd181: begin df = 6'd41; nf = 4'd0; end
			9'd182: begin df = 6'd41; nf = 4'd9; end
			default: begin df = 6'd0; nf = 4'd0; end
		endcase
		return {nf, df};
	endfunction

endpackage

[hw/rtl/idd_in_stage.sv]
module idd_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             desc_valid,
	output logic             desc_ready,
	input  idd_pkg::idd_in_t desc,
	output logic             valid_s1,
	input  logic             take_s1,
	output idd_pkg::idd_in_t desc_s1
);
	import idd_pkg::*;

	logic load;

	// stage frees up when empty or when its beat moves on this cycle
	assign desc_ready = !valid_s1 || take_s1;
	assign load       = desc_valid && desc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (desc_ready) begin
			valid_s1 <= desc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_s1 <= desc;
		end
	end

endmodule

[hw/rtl/idd_decode.sv]
module idd_decode (
	input  idd_pkg::idd_in_t  d,
	output idd_pkg::idd_out_t r
);
	import idd_pkg::*;

	logic [39:0] unit_addr;
	logic [14:0] width;
	logic [14:0] height;
	logic [11:0] min_lod;
	logic [3:0]  mip_first;
	logic [3:0]  mip_last;
	logic [4:0]  sw_mode;
	logic [3:0]  img_type;
	logic [15:0] depth;
	logic [15:0] slice;
	logic [3:0]  max_mip;
	logic        arrayed;
	logic        volumetric;
	logic [16:0] depth_p1;
	logic [16:0] layer_views;
	logic [4:0]  mips_raw;
	logic [4:0]  last_p1;
	logic [4:0]  mip_views;
	logic [9:0]  fmt;
	logic [5:0]  df;
	logic [6:0]  tiling;
	logic        align_en;
	logic [14:0] pitch_32;
	logic [14:0] pitch_64;
	logic [14:0] pitch;
	logic        collapse;

	assign unit_addr  = {d.word_one[7:0], d.word_zero};
	assign width      = {1'b0, d.word_two[11:0], d.word_one[31:30]} + 15'd1;
	assign height     = {1'b0, d.word_two[27:14]} + 15'd1;
	assign min_lod    = d.word_one[19:8];
	assign mip_first  = d.word_three[15:12];
	assign mip_last   = d.word_three[19:16];
	assign sw_mode    = d.word_three[24:20];
	assign img_type   = d.word_three[31:28];
	assign depth      = d.word_four[15:0];
	assign slice      = d.word_four[31:16];
	assign max_mip    = d.word_five[7:4];

	assign arrayed    = img_type inside {IMG_ARRAY_A, IMG_ARRAY_B};
	assign volumetric = img_type inside {IMG_3D_A, IMG_3D_B};

	// layer counts, view count clamped at one
	assign depth_p1    = {1'b0, depth} + 17'd1;
	assign layer_views = (arrayed && (depth_p1 > {1'b0, slice})) ?
		(depth_p1 - {1'b0, slice}) : 17'd1;

	// mip counts, view count clamped at one
	assign mips_raw  = {1'b0, max_mip} + 5'd1;
	assign last_p1   = {1'b0, mip_last} + 5'd1;
	assign mip_views = (last_p1 > {1'b0, mip_first}) ?
		(last_p1 - {1'b0, mip_first}) : 5'd1;

	assign fmt = idd_fmt_lookup(d.word_one[28:20]);
	assign df  = fmt[5:0];

	always_comb begin
		case (sw_mode)
			SWZ_LINEAR: tiling = TILE_LINEAR;
			SW_STD_A:   tiling = TILE_STD_A;
			SW_STD_B:   tiling = TILE_STD_B;
			SW_STD_C:   tiling = TILE_STD_C;
			default:    tiling = TILE_BASE | {2'b00, sw_mode};
		endcase
	end

	// linear pitch rounded up to a multiple of 32 for the narrow-align format, else 64
	assign align_en = (sw_mode == SWZ_LINEAR) && (df != 6'd0) && (df < DF_PITCH_LIMIT);
	assign pitch_32 = (width + 15'd31) & ~15'd31;
	assign pitch_64 = (width + 15'd63) & ~15'd63;
	always_comb begin
		if (!align_en) begin
			pitch = width;
		end else if (df == DF_NARROW_ALIGN) begin
			pitch = pitch_32;
		end else begin
			pitch = pitch_64;
		end
	end

	// standard tiled modes drop to a single mip level
	assign collapse = (tiling >= TILE_STD_A) && (tiling <= TILE_STD_C) && (mips_raw > 5'd1);

	always_comb begin
		r.base_address     = {unit_addr, 8'h00};
		r.image_width      = width;
		r.image_height     = height;
		r.row_pitch        = pitch;
		r.min_lod_out      = collapse ? 12'd0 : min_lod;
		r.mip_fields       = collapse ? {5'd1, 5'd1, 4'd0} :
			{mip_views, mips_raw, mip_first};
		r.layer_count      = (arrayed || volumetric) ? depth_p1 : 17'd1;
		r.view_layer_count = layer_views;
		r.base_slice       = slice;
		r.format_pair      = fmt;
		r.tiling_index     = tiling;
		r.status_flags     = {(unit_addr != 40'd0), collapse, arrayed, img_type};
	end

endmodule

[hw/rtl/idd_out_stage.sv]
module idd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	output logic              take_s1,
	input  idd_pkg::idd_out_t res_d,
	output logic              res_valid,
	input  logic              res_ready,
	output idd_pkg::idd_out_t res
);
	import idd_pkg::*;

	logic     valid_s2;
	idd_out_t res_s2;

	// output register frees up when empty or when its beat is taken
	assign take_s1   = valid_s1 && (!valid_s2 || res_ready);
	assign res_valid = valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			res_s2 <= res_d;
		end
	end

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |-> (!valid_s2 || res_ready))
		else $error("result register overwritten while stalled");

	// linear alignment never shrinks the pitch
	a_pitch_ge_width: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.row_pitch >= res_s2.image_width))
		else $error("row pitch below width");

	// collapsed mip chain starts at level zero with one level
	a_collapse_mips: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status_flags[5]) |->
		(res_s2.mip_fields[3:0] == 4'd0 && res_s2.min_lod_out == 12'd0 &&
		 res_s2.mip_fields[8:4] == 5'd1))
		else $error("mip collapse incomplete");

	// view layers never exceed the layer count and are never zero
	a_view_layers: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.view_layer_count <= res_s2.layer_count) &&
		(res_s2.view_layer_count != 17'd0))
		else $error("view layer count out of range");

endmodule

[hw/rtl/image_descriptor_decode_top.sv]
// image descriptor decoder
//
// takes the first six words of an image resource descriptor on the desc
// channel and returns one decoded result beat on the res channel for each
// descriptor beat; both channels use valid/ready and a beat moves on a
// rising edge with valid and ready both high
//
// path: an accepted descriptor is captured in the input register, decoded
// combinationally and moved into the result register once that register
// is free; res shows the result register
// throughput: one beat per cycle while res_ready stays high; the decode is
// plain field slicing, a 9-bit format table and a few short adds between
// the input register and the result register
//
// stall: while res_ready is low the result register holds its beat and
// the input register can still take one more descriptor; desc_ready then
// drops until res_ready returns
// reset: arst_n clears both valid flags; the data registers are not reset
module image_descriptor_decode_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	output logic              desc_ready,
	input  idd_pkg::idd_in_t  desc,
	output logic              res_valid,
	input  logic              res_ready,
	output idd_pkg::idd_out_t res
);
	import idd_pkg::*;

	// input register side
	logic     valid_s1;
	logic     take_s1;
	idd_in_t  desc_s1;

	// decoded beat, ahead of the result register
	idd_out_t res_d;

	// capture the raw descriptor words
	idd_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.valid_s1   (valid_s1),
		.take_s1    (take_s1),
		.desc_s1    (desc_s1)
	);

	// field unpack, format table, tiling and pitch, all combinational
	idd_decode u_decode (
		.d (desc_s1),
		.r (res_d)
	);

	// result register, holds a beat while the receiver stalls
	idd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.take_s1   (take_s1),
		.res_d     (res_d),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import idd_pkg::*;

	// swizzle modes and image types with no special handling
	localparam logic [4:0] SW_TILED_LO = 5'd2;
	localparam logic [4:0] SW_TILED_HI = 5'd31;
	localparam logic [3:0] IMG_PLAIN   = 4'd9;

	// unified format codes used by the directed beats
	localparam logic [8:0] UF_BYTE    = 9'd1;
	localparam logic [8:0] UF_UNKNOWN = 9'd3;
	localparam logic [8:0] UF_NARROW  = 9'd71;
	localparam logic [8:0] UF_WIDE    = 9'd169;
	localparam logic [8:0] UF_LAST    = 9'd182;

	// far beyond the slowest legal run with full idling on both sides
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 100;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     desc_valid = 1'b0;
	logic     desc_ready;
	idd_in_t  desc = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	idd_out_t res;

	// expected decodes, oldest first
	idd_out_t pending_decodes[$];
	idd_out_t want_res;
	int       mismatch_count = 0;
	int       cycle_count = 0;
	// percent chance per beat or cycle of starting an idle burst
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;

	image_descriptor_decode_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// unified format to {data format, number format}; zero when not in the table
	function automatic logic [9:0] format_entry(input logic [8:0] ufmt);
		logic [9:0] e;
		case (ufmt)
			9'd1:    e = {6'd1, 4'd0};
			9'd2:    e = {6'd1, 4'd1};
			9'd5:    e = {6'd1, 4'd4};
			9'd6:    e = {6'd1, 4'd5};
			9'd7:    e = {6'd2, 4'd0};
			9'd11:   e = {6'd2, 4'd4};
			9'd13:   e = {6'd2, 4'd7};
			9'd14:   e = {6'd3, 4'd0};
			9'd18:   e = {6'd3, 4'd4};
			9'd20:   e = {6'd4, 4'd4};
			9'd21:   e = {6'd4, 4'd5};
			9'd22:   e = {6'd4, 4'd7};
			9'd23:   e = {6'd5, 4'd0};
			9'd27:   e = {6'd5, 4'd4};
			9'd29:   e = {6'd5, 4'd7};
			9'd36:   e = {6'd6, 4'd7};
			9'd44:   e = {6'd9, 4'd0};
			9'd50:   e = {6'd8, 4'd0};
			9'd56:   e = {6'd10, 4'd0};
			9'd57:   e = {6'd10, 4'd1};
			9'd60:   e = {6'd10, 4'd4};
			9'd62:   e = {6'd11, 4'd4};
			9'd64:   e = {6'd11, 4'd7};
			9'd71:   e = {6'd12, 4'd7};
			9'd74:   e = {6'd13, 4'd7};
			9'd77:   e = {6'd14, 4'd7};
			9'd130:  e = {6'd10, 4'd9};
			9'd169:  e = {6'd35, 4'd0};
			9'd170:  e = {6'd35, 4'd9};
			9'd171:  e = {6'd36, 4'd0};
			9'd172:  e = {6'd36, 4'd9};
			9'd173:  e = {6'd37, 4'd0};
			9'd174:  e = {6'd37, 4'd9};
			9'd175:  e = {6'd38, 4'd0};
			9'd176:  e = {6'd38, 4'd1};
			9'd177:  e = {6'd39, 4'd0};
			9'd178:  e = {6'd39, 4'd1};
			9'd181:  e = {6'd41, 4'd0};
			9'd182:  e = {6'd41, 4'd9};
			default: e = 10'd0;
		endcase
		return e;
	endfunction

	// expected result beat for one descriptor
	function automatic idd_out_t decode_descriptor(input idd_in_t d);
		idd_out_t   r;
		logic [39:0] unit_addr;
		logic [11:0] lod;
		logic [9:0]  dfnf;
		logic [5:0]  df;
		logic [3:0]  nf;
		logic [3:0]  bmip;
		logic [3:0]  itype;
		logic [4:0]  mode;
		logic [6:0]  tile;
		logic        arrayed;
		logic        lod_zero;
		int          width;
		int          height;
		int          pitch;
		int          align;
		int          depth_p1;
		int          slice;
		int          layers;
		int          layer_views;
		int          mips;
		int          mip_views;
		unit_addr = {d.word_one[7:0], d.word_zero};
		lod       = d.word_one[19:8];
		width     = {d.word_two[11:0], d.word_one[31:30]} + 1;
		height    = d.word_two[27:14] + 1;
		bmip      = d.word_three[15:12];
		mode      = d.word_three[24:20];
		itype     = d.word_three[31:28];
		depth_p1  = d.word_four[15:0] + 1;
		slice     = d.word_four[31:16];
		mips      = d.word_five[7:4] + 1;
		mip_views = d.word_three[19:16] + 1 - bmip;
		if (mip_views < 1) begin
			mip_views = 1;
		end
		arrayed = (itype == IMG_ARRAY_A) || (itype == IMG_ARRAY_B);
		layers = (arrayed || itype == IMG_3D_A || itype == IMG_3D_B) ? depth_p1 : 1;
		layer_views = (arrayed && depth_p1 > slice) ? depth_p1 - slice : 1;
		dfnf = format_entry(d.word_one[28:20]);
		df   = dfnf[9:4];
		nf   = dfnf[3:0];
		case (mode)
			SWZ_LINEAR: tile = TILE_LINEAR;
			SW_STD_A:   tile = TILE_STD_A;
			SW_STD_B:   tile = TILE_STD_B;
			SW_STD_C:   tile = TILE_STD_C;
			default:    tile = TILE_BASE + {2'b00, mode};
		endcase
		pitch = width;
		if (mode == SWZ_LINEAR && df != 6'd0 && df < DF_PITCH_LIMIT) begin
			align = (df == DF_NARROW_ALIGN) ? 32 : 64;
			pitch = (width + align - 1) / align * align;
		end
		lod_zero = (tile == TILE_STD_A || tile == TILE_STD_B || tile == TILE_STD_C) && mips > 1;
		if (lod_zero) begin
			mips      = 1;
			mip_views = 1;
			bmip      = 4'd0;
			lod       = 12'd0;
		end
		r.base_address     = {unit_addr, 8'h00};
		r.image_width      = width[14:0];
		r.image_height     = height[14:0];
		r.row_pitch        = pitch[14:0];
		r.min_lod_out      = lod;
		r.mip_fields       = {mip_views[4:0], mips[4:0], bmip};
		r.layer_count      = layers[16:0];
		r.view_layer_count = layer_views[16:0];
		r.base_slice       = d.word_four[31:16];
		r.format_pair      = {nf, df};
		r.tiling_index     = tile;
		r.status_flags     = {unit_addr != 40'd0, lod_zero, arrayed, itype};
		return r;
	endfunction

	// pack descriptor fields, unused bits filled at random
	function automatic idd_in_t build_desc(
		input logic [39:0] unit_addr,
		input logic [11:0] lod,
		input logic [8:0]  ufmt,
		input logic [13:0] wm1,
		input logic [13:0] hm1,
		input logic [3:0]  bmip,
		input logic [3:0]  last_lvl,
		input logic [4:0]  mode,
		input logic [3:0]  itype,
		input logic [15:0] depth_m1,
		input logic [15:0] slice,
		input logic [3:0]  max_mip
	);
		idd_in_t     d;
		logic [31:0] fill_a;
		logic [31:0] fill_b;
		fill_a = $urandom;
		fill_b = $urandom;
		d.word_zero  = unit_addr[31:0];
		d.word_one   = {wm1[1:0], fill_a[0], ufmt, lod, unit_addr[39:32]};
		d.word_two   = {fill_a[4:1], hm1, fill_a[6:5], wm1[13:2]};
		d.word_three = {itype, fill_a[9:7], mode, last_lvl, bmip, fill_a[21:10]};
		d.word_four  = {slice, depth_m1};
		d.word_five  = {fill_b[31:8], max_mip, fill_b[3:0]};
		return d;
	endfunction

	// mostly well-formed descriptors biased towards the interesting cases
	function automatic idd_in_t random_desc();
		logic [31:0] r0;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
		logic [39:0] addr;
		logic [8:0]  ufmt;
		logic [4:0]  mode;
		logic [3:0]  itype;
		logic [15:0] depth_m1;
		logic [15:0] slice;
		logic [13:0] wm1;
		r0 = $urandom;
		r1 = $urandom;
		r2 = $urandom;
		r3 = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			return {r0, r1, r2, r3, $urandom, $urandom};
		end
		addr = {r0[7:0], r1};
		if ($urandom_range(0, 15) == 0) begin
			addr = 40'd0;
		end
		ufmt = ($urandom_range(0, 3) == 0) ? r2[8:0] : 9'($urandom_range(0, 183));
		case ($urandom_range(0, 3))
			0: mode = SWZ_LINEAR;
			1: begin
				case ($urandom_range(0, 2))
					0:       mode = SW_STD_A;
					1:       mode = SW_STD_B;
					default: mode = SW_STD_C;
				endcase
			end
			default: mode = r2[13:9];
		endcase
		itype = $urandom_range(0, 1) ? IMG_3D_A + 4'($urandom_range(0, 3)) : r2[17:14];
		depth_m1 = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : r3[15:0];
		slice = $urandom_range(0, 1) ? 16'($urandom_range(0, depth_m1 + 3)) : r3[31:16];
		wm1 = $urandom_range(0, 1) ? 14'($urandom_range(0, 300)) : r2[31:18];
		r0 = $urandom;
		r1 = $urandom;
		return build_desc(addr, r0[11:0], ufmt, wm1, r0[25:12], r0[29:26], r1[3:0],
			mode, itype, depth_m1, slice, r1[7:4]);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("%0t: mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [47:0] got, input logic [47:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	// drive one descriptor beat from a falling edge; returns at the falling edge
	// after it was taken, with its decode queued
	task automatic drive_descriptor(input idd_in_t d);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			desc_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		desc_valid <= 1'b1;
		desc       <= d;
		@(posedge clk);
		while (!desc_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		// queued after the accepting edge, so no result can race it
		pending_decodes.insert(pending_decodes.size(), decode_descriptor(d));
	endtask

	// receiver back-pressure, bursts of low ready
	always begin
		@(negedge clk);
		if ($urandom_range(0, 99) < recv_idle_pct) begin
			res_ready <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		res_ready <= 1'b1;
	end

	// result checker, sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				want_res = pending_decodes.pop_front();
				check_field("base_address", res.base_address, want_res.base_address);
				check_field("image_width", res.image_width, want_res.image_width);
				check_field("image_height", res.image_height, want_res.image_height);
				check_field("row_pitch", res.row_pitch, want_res.row_pitch);
				check_field("min_lod_out", res.min_lod_out, want_res.min_lod_out);
				check_field("mip_fields", res.mip_fields, want_res.mip_fields);
				check_field("layer_count", res.layer_count, want_res.layer_count);
				check_field("view_layer_count", res.view_layer_count,
					want_res.view_layer_count);
				check_field("base_slice", res.base_slice, want_res.base_slice);
				check_field("format_pair", res.format_pair, want_res.format_pair);
				check_field("tiling_index", res.tiling_index, want_res.tiling_index);
				check_field("status_flags", res.status_flags, want_res.status_flags);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// field extremes and every special case, light idling on both sides
	task automatic test_directed_cases();
		send_idle_pct = 15;
		recv_idle_pct = 15;
		// all-zero beat: zero base, unknown format, linear, nothing arrayed
		drive_descriptor('0);
		// all-ones beat: unknown format, top swizzle mode and type
		drive_descriptor('1);
		// widest surface, narrow-align format, full mip range
		drive_descriptor(build_desc(40'hFF_FFFF_FFFF, 12'hFFF, UF_NARROW, 14'h3FFF, 14'h3FFF,
			4'd0, 4'd15, SWZ_LINEAR, 4'd0, 16'd0, 16'd0, 4'd15));
		// one texel wide, linear, pitch rounds up to 64
		drive_descriptor(build_desc(40'h1, 12'h123, UF_BYTE, 14'd0, 14'd0,
			4'd0, 4'd0, SWZ_LINEAR, 4'd1, 16'd0, 16'd0, 4'd0));
		// narrow-align format just past a boundary
		drive_descriptor(build_desc(40'h80, 12'h0, UF_NARROW, 14'd32, 14'd7,
			4'd1, 4'd2, SWZ_LINEAR, 4'd1, 16'd0, 16'd0, 4'd3));
		// data format above the alignment range keeps its width
		drive_descriptor(build_desc(40'h12345, 12'h7, UF_WIDE, 14'd99, 14'd99,
			4'd0, 4'd0, SWZ_LINEAR, 4'd2, 16'd0, 16'd0, 4'd0));
		// unknown format on a linear surface: pitch equals width
		drive_descriptor(build_desc(40'h12345, 12'h7, UF_UNKNOWN, 14'd99, 14'd99,
			4'd0, 4'd0, SWZ_LINEAR, 4'd2, 16'd0, 16'd0, 4'd0));
		// view mip count would underflow, clamps to one
		drive_descriptor(build_desc(40'hABCDE, 12'h55, UF_BYTE, 14'd63, 14'd63,
			4'd9, 4'd3, SW_TILED_LO, 4'd1, 16'd0, 16'd0, 4'd9));
		// view mip count exactly zero before the clamp
		drive_descriptor(build_desc(40'hABCDE, 12'h55, UF_BYTE, 14'd63, 14'd63,
			4'd4, 4'd3, SW_TILED_LO, 4'd1, 16'd0, 16'd0, 4'd9));
		// mip collapse on each standard mode
		drive_descriptor(build_desc(40'h777, 12'hABC, UF_BYTE, 14'd200, 14'd100,
			4'd7, 4'd12, SW_STD_A, 4'd1, 16'd0, 16'd0, 4'd5));
		drive_descriptor(build_desc(40'h777, 12'hFFF, UF_LAST, 14'd200, 14'd100,
			4'd15, 4'd15, SW_STD_B, 4'd1, 16'd0, 16'd0, 4'd15));
		drive_descriptor(build_desc(40'h777, 12'h001, UF_BYTE, 14'd200, 14'd100,
			4'd2, 4'd1, SW_STD_C, 4'd1, 16'd0, 16'd0, 4'd1));
		// standard mode with a single mip level: no collapse
		drive_descriptor(build_desc(40'h777, 12'hABC, UF_BYTE, 14'd200, 14'd100,
			4'd3, 4'd8, SW_STD_C, 4'd1, 16'd0, 16'd0, 4'd0));
		// array views: ordinary, underflowing, widest
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_LO, IMG_ARRAY_A, 16'd7, 16'd3, 4'd0));
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_LO, IMG_ARRAY_B, 16'd2, 16'd9, 4'd0));
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_LO, IMG_ARRAY_B, 16'hFFFF, 16'd0, 4'd0));
		// base slice equal to the layer count
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_LO, IMG_ARRAY_A, 16'd4, 16'd5, 4'd0));
		// volume types count layers but have a single view layer
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_HI, IMG_3D_A, 16'hFFFF, 16'hFFFF, 4'd0));
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_HI, IMG_3D_B, 16'd30, 16'd2, 4'd0));
		// plain type ignores depth
		drive_descriptor(build_desc(40'h1000, 12'h0, UF_BYTE, 14'd15, 14'd15,
			4'd0, 4'd0, SW_TILED_HI, IMG_PLAIN, 16'd100, 16'd2, 4'd0));
		// zero base with everything else busy
		drive_descriptor(build_desc(40'h0, 12'hFFF, UF_LAST, 14'h3FFF, 14'h1234,
			4'd5, 4'd10, SW_TILED_HI, IMG_ARRAY_A, 16'd40, 16'd10, 4'd7));
	endtask

	// every unified format code once, odd codes forced onto linear surfaces
	task automatic test_format_sweep();
		idd_in_t d;
		send_idle_pct = 10;
		recv_idle_pct = 10;
		for (int uf = 0; uf < 512; uf++) begin
			d = random_desc();
			d.word_one[28:20] = uf[8:0];
			if (uf[0]) begin
				d.word_three[24:20] = SWZ_LINEAR;
			end
			drive_descriptor(d);
		end
	endtask

	// mixed random traffic: heavy idling first, then very little
	task automatic test_random_traffic();
		send_idle_pct = 30;
		recv_idle_pct = 30;
		for (int n = 0; n < 300; n++) begin
			drive_descriptor(random_desc());
		end
		send_idle_pct = 3;
		recv_idle_pct = 3;
		for (int n = 0; n < 300; n++) begin
			drive_descriptor(random_desc());
		end
	endtask

	// back-to-back beats with no idling on either side
	task automatic test_streaming();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int n = 0; n < 240; n++) begin
			drive_descriptor(random_desc());
		end
	endtask

	initial begin
		// reset held low from the start, released on a falling edge away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_format_sweep();
		test_random_traffic();
		test_streaming();

		desc_valid <= 1'b0;
		// drain, then wait for any stray beat to show
		while (pending_decodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/idd_pkg.sv
hw/rtl/idd_in_stage.sv
hw/rtl/idd_decode.sv
hw/rtl/idd_out_stage.sv
hw/rtl/image_descriptor_decode_top.sv
tb/sv/tb.sv
